// ----- rtl/wind_barb_line_path_assert.svh -----
// ----------------------------------------------------------------------------
// wind barb line path assertion macros
// shared property wrappers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef WIND_BARB_LINE_PATH_ASSERT_SVH
`define WIND_BARB_LINE_PATH_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define WBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wind barb line path check failed");

// next-cycle implication, disabled while reset is asserted
`define WBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wind barb line path check failed");

`endif

// ----- rtl/wbl_pkg.sv -----
// ----------------------------------------------------------------------------
// wbl_pkg
// types, fixed constants and the control program of the wind barb line path
// ----------------------------------------------------------------------------
package wbl_pkg;

	// sequencer steps, also the program addresses
	typedef enum logic [3:0] {
		ST_WAIT,
		ST_SCALE,
		ST_KNOTS,
		ST_FLAGS,
		ST_LONG,
		ST_SETUP,
		ST_STEM_MOVE,
		ST_STEM_LINE,
		ST_LONG_MOVE,
		ST_LONG_LINE,
		ST_SHORT_GAP,
		ST_SHORT_MOVE,
		ST_SHORT_LINE
	} step_t;

	// datapath operation of a step
	typedef enum logic [2:0] {
		OP_NOP,
		OP_WAIT,
		OP_SCALE,
		OP_KNOTS,
		OP_FLAGS,
		OP_LONG,
		OP_SETUP,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {X_ZERO, X_LONG, X_SHORT} xsel_t;
	typedef enum logic [1:0] {Y_ZERO, Y_CUR, Y_LONG, Y_SHORT} ysel_t;
	typedef enum logic [1:0] {YU_HOLD, YU_BASE, YU_STEP, YU_GAP} yupd_t;
	typedef enum logic [1:0] {LS_NONE, LS_STEM, LS_LONG, LS_ALWAYS} last_t;
	typedef enum logic [2:0] {
		J_NONE,
		J_ALWAYS,
		J_MISSING,
		J_SLOW,
		J_NO_LONG,
		J_MORE_LONG,
		J_NO_SHORT
	} jcond_t;

	// path commands
	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_LINE = 1'b1;

	// speed to knots: knots = (ws * 1800 + 118528) / (463 * 512)
	localparam int          P_W      = 27;
	localparam logic [10:0] KT_MUL   = 11'd1800;
	localparam logic [26:0] KT_BIAS  = 27'd118528;
	localparam int          KT_SHIFT = 9;
	// ceil(2^26 / 463), exact for every scaled speed below 2^18
	localparam logic [17:0] KT_RECIP = 18'd144944;
	localparam int          KT_RSH   = 26;
	// ceil(2^16 / 50) and ceil(2^11 / 10), exact on the ranges used
	localparam logic [10:0] DIV50_RECIP = 11'd1311;
	localparam logic [7:0]  DIV10_RECIP = 8'd205;
	localparam logic [8:0]  KNOTS_MIN   = 9'd5;

	// one control word
	typedef struct packed {
		op_t    op;
		logic   cmd;
		xsel_t  xsel;
		ysel_t  ysel;
		yupd_t  yupd;
		logic   cnt_dec;
		last_t  last_sel;
		jcond_t jcond;
		step_t  target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		uword_t word;
		logic   go;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic missing;
		logic slow;
		logic no_long;
		logic more_long;
		logic no_short;
		logic out_free;
	} status_t;

	// control program
	function automatic uword_t ucode(input step_t st);
		uword_t w;
		w = '{op: OP_NOP, cmd: CMD_MOVE, xsel: X_ZERO, ysel: Y_ZERO, yupd: YU_HOLD,
			cnt_dec: 1'b0, last_sel: LS_NONE, jcond: J_NONE, target: ST_WAIT};
		case (st)
			ST_WAIT: begin
				w.op = OP_WAIT;
			end
			ST_SCALE: begin
				w.op = OP_SCALE;
				w.jcond = J_MISSING;
			end
			ST_KNOTS: begin
				w.op = OP_KNOTS;
			end
			ST_FLAGS: begin
				w.op = OP_FLAGS;
				w.jcond = J_SLOW;
			end
			ST_LONG: begin
				w.op = OP_LONG;
			end
			ST_SETUP: begin
				w.op = OP_SETUP;
			end
			ST_STEM_MOVE: begin
				w.op = OP_EMIT;
			end
			ST_STEM_LINE: begin
				w.op = OP_EMIT;
				w.cmd = CMD_LINE;
				w.ysel = Y_CUR;
				w.yupd = YU_BASE;
				w.last_sel = LS_STEM;
				w.jcond = J_NO_LONG;
				w.target = ST_SHORT_GAP;
			end
			ST_LONG_MOVE: begin
				w.op = OP_EMIT;
				w.ysel = Y_CUR;
			end
			ST_LONG_LINE: begin
				w.op = OP_EMIT;
				w.cmd = CMD_LINE;
				w.xsel = X_LONG;
				w.ysel = Y_LONG;
				w.yupd = YU_STEP;
				w.cnt_dec = 1'b1;
				w.last_sel = LS_LONG;
				w.jcond = J_MORE_LONG;
				w.target = ST_LONG_MOVE;
			end
			ST_SHORT_GAP: begin
				w.yupd = YU_GAP;
				w.jcond = J_NO_SHORT;
			end
			ST_SHORT_MOVE: begin
				w.op = OP_EMIT;
				w.ysel = Y_CUR;
			end
			ST_SHORT_LINE: begin
				w.op = OP_EMIT;
				w.cmd = CMD_LINE;
				w.xsel = X_SHORT;
				w.ysel = Y_SHORT;
				w.last_sel = LS_ALWAYS;
				w.jcond = J_ALWAYS;
			end
			default: begin
				w.jcond = J_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/wbl_in_if.sv -----
// ----------------------------------------------------------------------------
// wbl_in_if
// speed item channel: valid, ready and the speed fields
// ----------------------------------------------------------------------------
interface wbl_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] wind_speed;
	logic        speed_missing;
	logic        southern;

	modport source (output valid, output wind_speed, output speed_missing,
		output southern, input ready);
	modport sink (input valid, input wind_speed, input speed_missing,
		input southern, output ready);
endinterface

// ----- rtl/wbl_out_if.sv -----
// ----------------------------------------------------------------------------
// wbl_out_if
// path command channel: valid, ready and one move or line command
// ----------------------------------------------------------------------------
interface wbl_out_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic               last;

	modport source (output valid, output command, output x_coord, output y_coord,
		output last, input ready);
	modport sink (input valid, input command, input x_coord, input y_coord,
		input last, output ready);
endinterface

// ----- rtl/wbl_seq.sv -----
// ----------------------------------------------------------------------------
// wbl_seq
// step counter and program lookup with conditional jumps
// ----------------------------------------------------------------------------
module wbl_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  wbl_pkg::status_t  status,
	output wbl_pkg::ctrl_t    ctrl,
	output logic              in_ready
);

	wbl_pkg::step_t  pc_q;
	wbl_pkg::step_t  pc_d;
	wbl_pkg::uword_t word;
	logic            go;
	logic            taken;

	// control word of the current step
	always_comb begin
		word = wbl_pkg::ucode(pc_q);
	end

	// stall on an empty input or a full output register
	always_comb begin
		case (word.op)
			wbl_pkg::OP_WAIT: go = in_valid;
			wbl_pkg::OP_EMIT: go = status.out_free;
			default:          go = 1'b1;
		endcase
	end

	// jump condition
	always_comb begin
		case (word.jcond)
			wbl_pkg::J_NONE:      taken = 1'b0;
			wbl_pkg::J_ALWAYS:    taken = 1'b1;
			wbl_pkg::J_MISSING:   taken = status.missing;
			wbl_pkg::J_SLOW:      taken = status.slow;
			wbl_pkg::J_NO_LONG:   taken = status.no_long;
			wbl_pkg::J_MORE_LONG: taken = status.more_long;
			wbl_pkg::J_NO_SHORT:  taken = status.no_short;
			default:              taken = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		pc_d = pc_q;
		if (go) begin
			if (taken) begin
				pc_d = word.target;
			end else begin
				pc_d = wbl_pkg::step_t'(pc_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= wbl_pkg::ST_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// outputs
	always_comb begin
		ctrl.word = word;
		ctrl.go = go;
		in_ready = (word.op == wbl_pkg::OP_WAIT);
	end

endmodule

// ----- rtl/wbl_dp.sv -----
// ----------------------------------------------------------------------------
// wbl_dp
// speed to knots arithmetic, barb counts, y walker and output register
// ----------------------------------------------------------------------------
module wbl_dp #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wbl_pkg::ctrl_t    ctrl,
	input  logic [15:0]       wind_speed,
	input  logic              speed_missing,
	input  logic              southern,
	output wbl_pkg::status_t  status,
	wbl_out_if.source         path
);

	localparam int F  = COORD_FRAC_BITS;
	// glyph spans under 128 units, so 7 integer bits plus sign
	localparam int YW = F + 8;

	// geometry, each rounded to the nearest 1/2^F
	localparam longint SPOT_C  = ((longint'(140) << F) + 50) / 100;
	localparam longint STEM_C  = longint'(18) << F;
	localparam longint INTV_C  = ((longint'(36) << F) + 5) / 10;
	localparam longint FLEN_C  = longint'(7) << F;
	localparam longint LDX_C   = ((longint'(64'd8485281374) << F) + 500000000) / 1000000000;
	localparam longint SDX_C   = ((longint'(64'd4242640687) << F) + 500000000) / 1000000000;
	localparam longint GAP_C   = ((longint'(54) << F) + 5) / 10;

	localparam logic signed [YW-1:0] BASE     = YW'(SPOT_C + STEM_C);
	localparam logic signed [YW-1:0] INTERVAL = YW'(INTV_C);
	localparam logic signed [YW-1:0] FLEN     = YW'(FLEN_C);
	localparam logic signed [YW-1:0] LDX      = YW'(LDX_C);
	localparam logic signed [YW-1:0] SDX      = YW'(SDX_C);
	localparam logic signed [YW-1:0] GAP      = YW'(GAP_C);

	wbl_pkg::uword_t w;

	logic [15:0]              ws_q;
	logic                     missing_q;
	logic                     south_q;
	logic [wbl_pkg::P_W-1:0]  p_q;
	logic [8:0]               knots_q;
	logic [3:0]               flags_q;
	logic [5:0]               rem_q;
	logic [2:0]               long_q;
	logic                     short_q;
	logic [2:0]               cnt_q;
	logic signed [YW-1:0]     y_q;

	logic                     out_valid_q;
	logic                     cmd_q;
	logic [15:0]              x_out_q;
	logic [15:0]              y_out_q;
	logic                     last_q;

	logic [35:0]              kprod;
	logic [19:0]              fprod;
	logic [8:0]               rem50;
	logic [13:0]              lprod;
	logic [5:0]               rem10;
	logic signed [YW-1:0]     flag_y;
	logic signed [YW-1:0]     y_top;
	logic signed [YW-1:0]     x_raw;
	logic signed [YW-1:0]     x_fin;
	logic signed [YW-1:0]     y_fin;
	logic                     last_v;
	logic                     emit;
	logic                     out_free;

	function automatic logic [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'h7fff;
		end else if (v < -32'sd32768) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	assign w = ctrl.word;

	// knots and the split into flags, long and short barbs
	always_comb begin
		kprod  = 36'(p_q[wbl_pkg::P_W-1:wbl_pkg::KT_SHIFT]) * 36'(wbl_pkg::KT_RECIP);
		fprod  = 20'(knots_q) * 20'(wbl_pkg::DIV50_RECIP);
		rem50  = knots_q - 9'(flags_q) * 9'd50;
		lprod  = 14'(rem50[5:0]) * 14'(wbl_pkg::DIV10_RECIP);
		rem10  = rem_q - 6'(long_q) * 6'd10;
		flag_y = $signed(YW'(flags_q)) * FLEN;
		y_top  = (flags_q != 4'd0) ? BASE + flag_y + INTERVAL : BASE;
	end

	// input capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			case (w.op)
				wbl_pkg::OP_WAIT: begin
					ws_q <= wind_speed;
					missing_q <= speed_missing;
					south_q <= southern;
				end
				wbl_pkg::OP_SCALE: begin
					p_q <= wbl_pkg::P_W'(ws_q) * wbl_pkg::P_W'(wbl_pkg::KT_MUL)
						+ wbl_pkg::KT_BIAS;
				end
				wbl_pkg::OP_KNOTS: begin
					knots_q <= kprod[wbl_pkg::KT_RSH+8:wbl_pkg::KT_RSH];
				end
				wbl_pkg::OP_FLAGS: begin
					flags_q <= fprod[19:16];
				end
				wbl_pkg::OP_LONG: begin
					rem_q <= rem50[5:0];
					long_q <= lprod[13:11];
				end
				default: begin
				end
			endcase
		end
	end

	// barb counter and y walker
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			if (w.op == wbl_pkg::OP_SETUP) begin
				short_q <= (rem10 >= 6'd5);
				cnt_q <= long_q;
				y_q <= y_top;
			end else begin
				if (w.cnt_dec) begin
					cnt_q <= cnt_q - 3'd1;
				end
				case (w.yupd)
					wbl_pkg::YU_BASE: y_q <= BASE;
					wbl_pkg::YU_STEP: y_q <= y_q - INTERVAL;
					wbl_pkg::YU_GAP: begin
						if (flags_q == 4'd0 && long_q == 3'd0) begin
							y_q <= y_q - GAP;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// coordinates of the command being issued
	always_comb begin
		case (w.xsel)
			wbl_pkg::X_ZERO:  x_raw = '0;
			wbl_pkg::X_LONG:  x_raw = -LDX;
			wbl_pkg::X_SHORT: x_raw = -SDX;
			default:          x_raw = '0;
		endcase
		x_fin = south_q ? -x_raw : x_raw;
		case (w.ysel)
			wbl_pkg::Y_ZERO:  y_fin = '0;
			wbl_pkg::Y_CUR:   y_fin = y_q;
			wbl_pkg::Y_LONG:  y_fin = y_q + LDX;
			wbl_pkg::Y_SHORT: y_fin = y_q + SDX;
			default:          y_fin = '0;
		endcase
		case (w.last_sel)
			wbl_pkg::LS_NONE:   last_v = 1'b0;
			wbl_pkg::LS_STEM:   last_v = (long_q == 3'd0) && !short_q;
			wbl_pkg::LS_LONG:   last_v = (cnt_q == 3'd1) && !short_q;
			wbl_pkg::LS_ALWAYS: last_v = 1'b1;
			default:            last_v = 1'b0;
		endcase
	end

	assign emit = ctrl.go && (w.op == wbl_pkg::OP_EMIT);
	assign out_free = !out_valid_q || path.ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (path.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cmd_q <= w.cmd;
			x_out_q <= sat16(32'(x_fin));
			y_out_q <= sat16(32'(y_fin));
			last_q <= last_v;
		end
	end

	assign path.valid   = out_valid_q;
	assign path.command = cmd_q;
	assign path.x_coord = $signed(x_out_q);
	assign path.y_coord = $signed(y_out_q);
	assign path.last    = last_q;

	// status to the sequencer
	always_comb begin
		status.missing   = missing_q;
		status.slow      = (knots_q < wbl_pkg::KNOTS_MIN);
		status.no_long   = (cnt_q == 3'd0);
		status.more_long = (cnt_q != 3'd1);
		status.no_short  = !short_q;
		status.out_free  = out_free;
	end

endmodule

// ----- rtl/wind_barb_line_path.sv -----
// ----------------------------------------------------------------------------
// wind_barb_line_path
// wind speed to move/line commands for the stem and barbs of a wind barb
//
//   channel  dir  fields                                  accepted when
//   sample   in   wind_speed, speed_missing, southern     valid && ready
//   path     out  command, x_coord, y_coord, last         valid && ready
//
// a missing speed ends the item after the scale step, one under five knots
// after the flags step; otherwise the program emits a move and a line for
// the stem and each barb, one step of the control program per cycle while
// sample and path do not stall it. a stalled path holds the sequencer on
// its next command; sample is taken again once the program is back at its
// wait step, while the final command may still sit in the output register.
// reset returns the program to its wait step and empties the output.
// ----------------------------------------------------------------------------
`include "wind_barb_line_path_assert.svh"

module wind_barb_line_path #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	wbl_in_if.sink     sample,
	wbl_out_if.source  path
);

	wbl_pkg::ctrl_t   ctrl;
	wbl_pkg::status_t status;
	logic             in_ready;

	// program sequencer
	wbl_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.status   (status),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	assign sample.ready = in_ready;

	// datapath and output register
	wbl_dp #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.wind_speed    (sample.wind_speed),
		.speed_missing (sample.speed_missing),
		.southern      (sample.southern),
		.status        (status),
		.path          (path)
	);

	// one item in work at a time
	`WBL_ASSERT_NEXT(a_one_item, clk, arst_n, sample.valid && sample.ready, !sample.ready)
	// a stalled command stays valid
	`WBL_ASSERT_NEXT(a_stall_hold, clk, arst_n, path.valid && !path.ready, path.valid)
	// a glyph always ends on a line command
	`WBL_ASSERT_IMP(a_move_not_last, clk, arst_n, path.valid && path.command == wbl_pkg::CMD_MOVE, !path.last)

endmodule
